>>> rtl/core/generational_slot_pool_top_macros.svh
// Assertion macros used by the slot pool datapath.
`ifndef GENERATIONAL_SLOT_POOL_TOP_MACROS_SVH
`define GENERATIONAL_SLOT_POOL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GSP_ASSERT_HOLD(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GSP_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/core/gsp_pkg.sv
// Shared types and constants of the generational slot pool.
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

	localparam int GEN_W = 31;
	localparam logic [GEN_W-1:0] GEN_MAX = 31'h7FFF_FFFF;
	localparam int POOL_W = 7;
	localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		ACT_ACQ = 2'd0,
		ACT_REL = 2'd1,
		ACT_ALL = 2'd2,
		ACT_QRY = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_NEW   = 2'd0,
		ST_FOUND = 2'd1,
		ST_REJ   = 2'd2
	} stat_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		act_t in_act;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gsp_ctrl.sv
// Sequencer of the slot pool: accept, scan (acquire only), commit.
`timescale 1ns / 1ps
`default_nettype none

module gsp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire gsp_pkg::dp_status_t dp_st,
	output gsp_pkg::cmd_t            cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;

	assign s_tready   = (state_q == S_IDLE);
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_FIN) && dp_st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= (dp_st.in_act == gsp_pkg::ACT_ACQ) ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					if (dp_st.scan_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (dp_st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gsp_datapath.sv
// Slot state, key/generation store, scan trackers and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_slot_pool_top_macros.svh"

module gsp_datapath #(
	parameter int SLOTS = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [gsp_pkg::POOL_W-1:0]          cfg_wr_data,
	input  wire logic [gsp_pkg::IN_DATA_W-1:0]       s_tdata,
	input  wire logic [1:0]                          s_tuser,
	input  wire gsp_pkg::cmd_t                       cmd,
	output gsp_pkg::dp_status_t                      dp_st,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [gsp_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int GW   = gsp_pkg::GEN_W;
	localparam int RW   = KW + GW;
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam int XW   = ((IW > gsp_pkg::POOL_W) ? IW : gsp_pkg::POOL_W) + 1;

	// Input beat fields
	logic [KW-1:0] in_key;
	logic [5:0]    in_idx;

	assign in_key = KW'(s_tdata[31:0]);
	assign in_idx = s_tdata[37:32];

	// Held request
	gsp_pkg::act_t act_q;
	logic [KW-1:0] key_q;
	logic [5:0]    idx_q;
	logic [GW-1:0] hgen_q;

	logic [gsp_pkg::POOL_W-1:0] pool_size_q;
	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] written_q;
	logic [CNTW-1:0]  count_q;

	// Scan trackers
	logic [IW-1:0] cmp_idx_s1;
	logic          match_q;
	logic [IW-1:0] match_slot_q;
	logic [GW-1:0] match_gen_q;
	logic          free_q;
	logic [IW-1:0] free_slot_q;
	logic [GW-1:0] free_gen_q;

	logic          out_valid_q;
	logic [gsp_pkg::OUT_DATA_W-1:0] out_data_q;

	// Store port signals
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic [RW-1:0] rd_data;
	logic [KW-1:0] rd_key;
	logic [GW-1:0] rd_gen;
	logic          claim;
	logic [GW-1:0] bump_gen;

	assign rd_key = rd_data[RW-1:GW];
	assign rd_gen = rd_data[GW-1:0];

	always_comb begin
		rd_en = cmd.load || cmd.scan;
		if (cmd.load) begin
			rd_addr = (gsp_pkg::act_t'(s_tuser) == gsp_pkg::ACT_ACQ) ? '0 : IW'(in_idx);
		end else begin
			rd_addr = cmp_idx_s1 + IW'(1);
		end
	end

	assign bump_gen = (free_gen_q >= gsp_pkg::GEN_MAX) ? GW'(1) : free_gen_q + GW'(1);

	gsp_ram #(
		.WIDTH(RW),
		.DEPTH(SLOTS)
	) u_store (
		.clk     (clk),
		.wr_en   (claim),
		.wr_addr (free_slot_q),
		.wr_data ({key_q, bump_gen}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Per-entry scan tests
	logic          hit;
	logic          free_ok;
	logic [GW-1:0] eff_gen;

	assign hit     = active_q[cmp_idx_s1] && (rd_key == key_q);
	assign free_ok = !active_q[cmp_idx_s1] && (XW'(cmp_idx_s1) < XW'(pool_size_q));
	assign eff_gen = written_q[cmp_idx_s1] ? rd_gen : '0;

	// Handle check for release and query
	logic          idx_ok;
	logic [IW-1:0] idx_a;
	logic          live;

	assign idx_ok = XW'(idx_q) < XW'(SLOTS);
	assign idx_a  = IW'(idx_q);
	assign live   = idx_ok && (hgen_q != '0) && active_q[idx_a] && (rd_gen == hgen_q);

	// Result of the held request
	gsp_pkg::stat_t res_status;
	logic [IW-1:0]  res_slot;
	logic [GW-1:0]  res_gen;
	logic [CNTW-1:0] count_nxt;

	assign claim = cmd.commit && (act_q == gsp_pkg::ACT_ACQ) && (key_q != '0)
		&& !match_q && free_q;

	always_comb begin
		res_status = gsp_pkg::ST_REJ;
		res_slot   = '0;
		res_gen    = '0;
		count_nxt  = count_q;
		case (act_q)
			gsp_pkg::ACT_ACQ: begin
				if (key_q != '0) begin
					if (match_q) begin
						res_status = gsp_pkg::ST_FOUND;
						res_slot   = match_slot_q;
						res_gen    = match_gen_q;
					end else if (free_q) begin
						res_status = gsp_pkg::ST_NEW;
						res_slot   = free_slot_q;
						res_gen    = bump_gen;
						count_nxt  = count_q + CNTW'(1);
					end
				end
			end
			gsp_pkg::ACT_REL: begin
				if (live) begin
					res_status = gsp_pkg::ST_NEW;
					count_nxt  = count_q - CNTW'(1);
				end
			end
			gsp_pkg::ACT_ALL: begin
				res_status = gsp_pkg::ST_NEW;
				count_nxt  = '0;
			end
			gsp_pkg::ACT_QRY: begin
				res_status = live ? gsp_pkg::ST_NEW : gsp_pkg::ST_REJ;
			end
			default: begin
				res_status = gsp_pkg::ST_REJ;
			end
		endcase
	end

	// Request payload, scan tracker slots and result data: no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= gsp_pkg::act_t'(s_tuser);
			key_q  <= in_key;
			idx_q  <= in_idx;
			hgen_q <= s_tdata[68:38];
		end
		if (cmd.scan) begin
			if (hit && !match_q) begin
				match_slot_q <= cmp_idx_s1;
				match_gen_q  <= rd_gen;
			end
			if (free_ok && !free_q) begin
				free_slot_q <= cmp_idx_s1;
				free_gen_q  <= eff_gen;
			end
		end
		if (cmd.commit) begin
			out_data_q <= {2'b00, gsp_pkg::POOL_W'(count_nxt), res_gen, 6'(res_slot),
				res_status};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= gsp_pkg::POOL_RESET;
			active_q    <= '0;
			written_q   <= '0;
			count_q     <= '0;
			cmp_idx_s1  <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pool_size_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				cmp_idx_s1 <= '0;
				match_q    <= 1'b0;
				free_q     <= 1'b0;
			end else if (cmd.scan) begin
				cmp_idx_s1 <= cmp_idx_s1 + IW'(1);
				if (hit) begin
					match_q <= 1'b1;
				end
				if (free_ok) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q <= count_nxt;
				if (claim) begin
					active_q[free_slot_q]  <= 1'b1;
					written_q[free_slot_q] <= 1'b1;
				end else if (act_q == gsp_pkg::ACT_REL && live) begin
					active_q[idx_a] <= 1'b0;
				end else if (act_q == gsp_pkg::ACT_ALL) begin
					active_q <= '0;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dp_st.in_act    = gsp_pkg::act_t'(s_tuser);
	assign dp_st.scan_last = (cmp_idx_s1 == IW'(SLOTS - 1));
	assign dp_st.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`GSP_ASSERT_HOLD(a_count_tracks, 1'b1, CNTW'($countones(active_q)) == count_q, "active count drifted from active bits")
	`GSP_ASSERT_HOLD(a_count_bound, 1'b1, count_q <= CNTW'(SLOTS), "active count above pool depth")
	`GSP_ASSERT_NEXT(a_all_clears, cmd.commit && act_q == gsp_pkg::ACT_ALL, count_q == '0 && active_q == '0, "release all left slots active")
	`GSP_ASSERT_NEXT(a_claim_marks, claim, active_q[free_slot_q] && written_q[free_slot_q], "claimed slot not marked active")
	`GSP_ASSERT_HOLD(a_commit_room, cmd.commit, !out_valid_q || m_tready, "result overwrote a pending beat")

endmodule

`default_nettype wire

>>> rtl/core/generational_slot_pool_top.sv
// Top level of the generational slot pool: sequencer plus datapath.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready   | tuser: action; tdata: key, index, generation
//  m_*     | out | m_tvalid / m_tready   | tdata: status, slot, generation, count
//  cfg_*   | in  | cfg_wr_en (no wait)   | cfg_wr_data: pool_size
//
// Acquire: one key/generation entry scanned per cycle, over all SLOTS entries.
// Release, release all and query go to commit without a scan.
// Reset clears active and generation-written bits, the count, and sets pool_size to 64;
// an unwritten generation reads as zero, so no clearing pass runs.
// One request in flight; the next beat is accepted while a result waits, and
// m_tready low holds only the commit of that next result.
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_pool_top #(
	parameter int SLOTS = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: pool_size
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data,
	// Request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // decal_key[31:0], slot_index[37:32],
	                                    // slot_generation[68:38], zero pad[71:69]
	input  wire logic [1:0]  s_tuser,   // action[1:0]
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata    // status[1:0], granted_slot[7:2],
	                                    // granted_generation[38:8],
	                                    // active_count[45:39], zero pad[47:46]
);

	gsp_pkg::cmd_t       cmd;
	gsp_pkg::dp_status_t dp_st;

	// Sequencer: owns the input handshake and steps the datapath
	gsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.dp_st    (dp_st),
		.cmd      (cmd)
	);

	// Datapath: slot state, key/generation store, result register
	gsp_datapath #(
		.SLOTS     (SLOTS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cmd         (cmd),
		.dp_st       (dp_st),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire
